// ----- rtl/vec4_keyframe_lerp_macros.svh -----
// Assertion macros shared by the keyframe interpolator RTL.
`ifndef VEC4_KEYFRAME_LERP_MACROS_SVH
`define VEC4_KEYFRAME_LERP_MACROS_SVH

`ifndef SYNTHESIS
`define VKL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VKL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VKL_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define VKL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/vkl_pkg.sv -----
// Shared widths, register indexes, codes and sequencer states of the keyframe interpolator.
package vkl_pkg;

   localparam int VAL_W        = 32;
   localparam int COMP_N       = 4;
   localparam int KEY_W        = VAL_W * (COMP_N + 1);
   localparam int MAX_KEYS_DEF = 16;
   localparam int SPEED_W      = 16;
   localparam int FRAC_BITS    = 16;
   localparam int FRAC_W       = FRAC_BITS + 1;
   localparam int DIV_CNT_W    = $clog2(FRAC_BITS);
   localparam int REQ_DATA_W   = VAL_W * (COMP_N + 2);
   localparam int RSP_DATA_W   = VAL_W * COMP_N;
   localparam int MUL_A_W      = VAL_W + 2;
   localparam int MUL_B_W      = FRAC_W + 1;
   localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_IDX_W    = 3;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;
   localparam logic [FRAC_W-1:0]  FRAC_ONE    = {1'b1, {FRAC_BITS{1'b0}}};

   // register indexes (byte address / 4)
   localparam logic [REG_IDX_W-1:0] REG_SPEED   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_STOPPED = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_INIT_X  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_INIT_Y  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_INIT_Z  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_INIT_W  = 3'd5;

   // item kinds carried on tuser
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_APPEND = 1'b1;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_MUL       = 10'b00_0000_0010,
      ST_STEP      = 10'b00_0000_0100,
      ST_SCAN_RD   = 10'b00_0000_1000,
      ST_SCAN_CHK  = 10'b00_0001_0000,
      ST_DIV_SETUP = 10'b00_0010_0000,
      ST_DIVIDE    = 10'b00_0100_0000,
      ST_LERP_MUL  = 10'b00_1000_0000,
      ST_LERP_ADD  = 10'b01_0000_0000,
      ST_FINISH    = 10'b10_0000_0000
   } state_type;

endpackage

// ----- rtl/vec4_keyframe_lerp.sv -----
// Top level of the four-component Q16.16 keyframe interpolator.
// Append beats and ticks while stopped are handled in IDLE; nothing is emitted.
// A tick scales delta by speed, steps the timer and reads the keys in turn on the key RAM read
// port until one brackets the timer (with none, it goes straight to the result); then it runs
// the serial divider for the 16 fraction bits unless the fraction is one, then blends on the multiplier.
// Reset is synchronous: speed 1.0, timer/keys/held value cleared; the key RAM is not swept.
`include "vec4_keyframe_lerp_macros.svh"

module vec4_keyframe_lerp
   import vkl_pkg::*;
#(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input beats
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // delta_time[31:0], key_time[63:32], key_x[95:64], key_y[127:96],
   // key_z[159:128], key_w[191:160]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[0]: 0 tick, 1 append keyframe
   input  logic                  req_tuser,
   // result beats
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // at_end[0]
   output logic                  rsp_tuser,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CW = $clog2(MAX_KEYS + 1);

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   state_type                     state_ff, state_in;
   logic [SPEED_W-1:0]            speed_ff, speed_in;
   logic                          stopped_ff, stopped_in;
   logic [COMP_N-1:0][VAL_W-1:0]  init_ff, init_in;
   logic [COMP_N-1:0][VAL_W-1:0]  held_ff, held_in;
   logic [VAL_W-1:0]              timer_ff, timer_in;
   logic [VAL_W-1:0]              max_dur_ff, max_dur_in;
   logic [CW-1:0]                 key_count_ff, key_count_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // datapath registers, no reset needed
   logic [VAL_W-1:0]              delta_ff, delta_in;
   logic signed [MUL_P_W-1:0]     prod_ff, prod_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [VAL_W-1:0]              prev_t_ff, prev_t_in;
   logic [COMP_N-1:0][VAL_W-1:0]  prev_v_ff, prev_v_in;
   logic [VAL_W-1:0]              next_t_ff, next_t_in;
   logic [COMP_N-1:0][VAL_W-1:0]  next_v_ff, next_v_in;
   logic [VAL_W-1:0]              rem_ff, rem_in;
   logic [VAL_W-1:0]              span_ff, span_in;
   logic [FRAC_W-1:0]             frac_ff, frac_in;
   logic [DIV_CNT_W-1:0]          div_cnt_ff, div_cnt_in;
   logic [1:0]                    comp_ff, comp_in;
   logic [COMP_N-1:0][VAL_W-1:0]  last_v_ff, last_v_in;
   logic [COMP_N-1:0][VAL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                          rsp_at_end_ff, rsp_at_end_in;

   // ---------------------------------------------------------------
   // Handshakes and register port decode
   // ---------------------------------------------------------------
   logic                  req_accept;
   logic                  csr_wr;
   logic [REG_IDX_W-1:0]  csr_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      unique case (csr_idx)
         REG_SPEED:   csr_prdata = {{(CSR_DATA_W-SPEED_W){1'b0}}, speed_ff};
         REG_STOPPED: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, stopped_ff};
         REG_INIT_X:  csr_prdata = init_ff[0];
         REG_INIT_Y:  csr_prdata = init_ff[1];
         REG_INIT_Z:  csr_prdata = init_ff[2];
         REG_INIT_W:  csr_prdata = init_ff[3];
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Key RAM: entry = {w, z, y, x, time}
   // ---------------------------------------------------------------
   logic             ram_wr_en;
   logic [KEY_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [KEY_W-1:0] ram_rd_data;
   logic [VAL_W-1:0] key_t_rd;
   logic [COMP_N-1:0][VAL_W-1:0] key_v_rd;

   assign ram_wr_en   = req_accept && (req_tuser == FUNC_APPEND) &&
                        (key_count_ff < CW'(MAX_KEYS));
   assign ram_wr_data = req_tdata[REQ_DATA_W-1:VAL_W];
   assign ram_rd_en   = (state_ff == ST_SCAN_RD);
   assign key_t_rd    = ram_rd_data[VAL_W-1:0];
   assign key_v_rd    = ram_rd_data[KEY_W-1:VAL_W];

   vkl_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (key_count_ff[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // Shared signed multiplier: delta * speed for the timer step,
   // (next - prev) * frac for each component.
   // ---------------------------------------------------------------
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic [VAL_W-1:0]          prev_c;
   logic [VAL_W-1:0]          next_c;
   logic [VAL_W:0]            diff_c;

   assign prev_c = prev_v_ff[comp_ff];
   assign next_c = next_v_ff[comp_ff];
   assign diff_c = {next_c[VAL_W-1], next_c} - {prev_c[VAL_W-1], prev_c};

   always_comb begin
      if (state_ff == ST_MUL) begin
         mul_a = {2'b00, delta_ff};
         mul_b = {2'b00, speed_ff};
      end else begin
         mul_a = {diff_c[VAL_W], diff_c};
         mul_b = {1'b0, frac_ff};
      end
   end

   assign mul_p = mul_a * mul_b;

   // ---------------------------------------------------------------
   // Timer step, divider step, end detect
   // ---------------------------------------------------------------
   logic [VAL_W+8:0]   timer_sum;
   logic [VAL_W:0]     rem_dbl;
   logic               rem_ge;
   logic [VAL_W-1:0]   num_setup;
   logic [VAL_W-1:0]   span_setup;
   logic               at_end;
   logic               rsp_load;

   // step = product >> 8 (40 bits), add with a carry bit to saturate on
   assign timer_sum = {9'b0, timer_ff} + {1'b0, prod_ff[VAL_W+SPEED_W-1:8]};
   assign rem_dbl   = {rem_ff, 1'b0};
   assign rem_ge    = (rem_dbl >= {1'b0, span_ff});
   assign num_setup  = timer_ff - prev_t_ff;
   assign span_setup = next_t_ff - prev_t_ff;
   assign at_end   = (key_count_ff != '0) && (timer_ff >= max_dur_ff);
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      speed_in      = speed_ff;
      stopped_in    = stopped_ff;
      init_in       = init_ff;
      held_in       = held_ff;
      timer_in      = timer_ff;
      max_dur_in    = max_dur_ff;
      key_count_in  = key_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      delta_in      = delta_ff;
      prod_in       = prod_ff;
      idx_in        = idx_ff;
      prev_t_in     = prev_t_ff;
      prev_v_in     = prev_v_ff;
      next_t_in     = next_t_ff;
      next_v_in     = next_v_ff;
      rem_in        = rem_ff;
      span_in       = span_ff;
      frac_in       = frac_ff;
      div_cnt_in    = div_cnt_ff;
      comp_in       = comp_ff;
      last_v_in     = last_v_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_at_end_in = rsp_at_end_ff;

      // drop the result beat once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // init register writes also load the held component
      if (csr_wr) begin
         unique case (csr_idx)
            REG_SPEED:   speed_in   = csr_pwdata[SPEED_W-1:0];
            REG_STOPPED: stopped_in = csr_pwdata[0];
            REG_INIT_X: begin
               init_in[0] = csr_pwdata;
               held_in[0] = csr_pwdata;
            end
            REG_INIT_Y: begin
               init_in[1] = csr_pwdata;
               held_in[1] = csr_pwdata;
            end
            REG_INIT_Z: begin
               init_in[2] = csr_pwdata;
               held_in[2] = csr_pwdata;
            end
            REG_INIT_W: begin
               init_in[3] = csr_pwdata;
               held_in[3] = csr_pwdata;
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == FUNC_APPEND) begin
                  // full table: drop the key
                  if (ram_wr_en) begin
                     if (req_tdata[2*VAL_W-1:VAL_W] > max_dur_ff) begin
                        max_dur_in = req_tdata[2*VAL_W-1:VAL_W];
                     end
                     last_v_in    = req_tdata[REQ_DATA_W-1:2*VAL_W];
                     key_count_in = CW'(key_count_ff + 1'b1);
                  end
               end else if (!stopped_ff) begin
                  delta_in = req_tdata[VAL_W-1:0];
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = mul_p;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            timer_in = (timer_sum[VAL_W+8:VAL_W] != '0) ? '1 : timer_sum[VAL_W-1:0];
            idx_in   = '0;
            state_in = (key_count_ff == '0) ? ST_FINISH : ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (key_t_rd >= timer_ff) begin
               // bracket found: before the first key, start from the init values
               next_t_in = key_t_rd;
               next_v_in = key_v_rd;
               if (idx_ff == '0) begin
                  prev_t_in = '0;
                  prev_v_in = init_ff;
               end
               state_in = ST_DIV_SETUP;
            end else begin
               prev_t_in = key_t_rd;
               prev_v_in = key_v_rd;
               idx_in    = CW'(idx_ff + 1'b1);
               state_in  = (CW'(idx_ff + 1'b1) == key_count_ff) ? ST_FINISH : ST_SCAN_RD;
            end
         end
         ST_DIV_SETUP: begin
            comp_in = '0;
            // equal num and span (also a zero span) gives a fraction of one
            if (num_setup == span_setup) begin
               frac_in  = FRAC_ONE;
               state_in = ST_LERP_MUL;
            end else begin
               rem_in     = num_setup;
               span_in    = span_setup;
               frac_in    = '0;
               div_cnt_in = DIV_CNT_W'(FRAC_BITS - 1);
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (rem_ge) begin
               rem_in = VAL_W'(rem_dbl - {1'b0, span_ff});
            end else begin
               rem_in = rem_dbl[VAL_W-1:0];
            end
            frac_in    = {frac_ff[FRAC_W-2:0], rem_ge};
            div_cnt_in = DIV_CNT_W'(div_cnt_ff - 1'b1);
            if (div_cnt_ff == '0) begin
               state_in = ST_LERP_MUL;
            end
         end
         ST_LERP_MUL: begin
            prod_in  = mul_p;
            state_in = ST_LERP_ADD;
         end
         ST_LERP_ADD: begin
            // floor(p / 65536) truncated to 32 bits is prod[47:16]
            held_in[comp_ff] = prev_c + prod_ff[VAL_W+FRAC_BITS-1:FRAC_BITS];
            comp_in          = comp_ff + 2'd1;
            state_in         = (comp_ff == 2'(COMP_N - 1)) ? ST_FINISH : ST_LERP_MUL;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (rsp_load) begin
               held_in       = at_end ? last_v_ff : held_ff;
               rsp_data_in   = at_end ? last_v_ff : held_ff;
               rsp_at_end_in = at_end;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         speed_ff     <= SPEED_RESET;
         stopped_ff   <= 1'b0;
         init_ff      <= '0;
         held_ff      <= '0;
         timer_ff     <= '0;
         max_dur_ff   <= '0;
         key_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         speed_ff     <= speed_in;
         stopped_ff   <= stopped_in;
         init_ff      <= init_in;
         held_ff      <= held_in;
         timer_ff     <= timer_in;
         max_dur_ff   <= max_dur_in;
         key_count_ff <= key_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff      <= delta_in;
      prod_ff       <= prod_in;
      idx_ff        <= idx_in;
      prev_t_ff     <= prev_t_in;
      prev_v_ff     <= prev_v_in;
      next_t_ff     <= next_t_in;
      next_v_ff     <= next_v_in;
      rem_ff        <= rem_in;
      span_ff       <= span_in;
      frac_ff       <= frac_in;
      div_cnt_ff    <= div_cnt_in;
      comp_ff       <= comp_in;
      last_v_ff     <= last_v_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_at_end_ff <= rsp_at_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_at_end_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `VKL_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, key_count_ff <= CW'(MAX_KEYS), "key count past table size")
   `VKL_ASSERT_SAME(a_div_rem, clock, reset, state_ff == ST_DIVIDE, rem_ff < span_ff, "divider remainder not below span")
   `VKL_ASSERT_SAME(a_frac_bound, clock, reset, state_ff == ST_LERP_MUL, frac_ff <= FRAC_ONE, "fraction above one")
   `VKL_ASSERT_NEXT(a_tick_start, clock, reset, req_accept && (req_tuser == FUNC_TICK) && !stopped_ff, state_ff == ST_MUL, "running tick did not start")
   `VKL_ASSERT_SAME(a_end_keys, clock, reset, rsp_valid_ff && rsp_at_end_ff, key_count_ff != '0, "end flagged without keys")

endmodule

// ----- rtl/vkl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module vkl_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/sv/keyframe_pose_check.sv -----
// Pose predictor and result comparison for the vec4 keyframe interpolator.
module keyframe_pose_check
   import vkl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    pose_errors,
   output int                    poses_due
);

   typedef logic [COMP_N-1:0][VAL_W-1:0] vec4_type;

   typedef struct packed {
      vec4_type comp;
      logic     at_end;
   } pose_type;

   // shadow of the block's registers and animation state
   logic [SPEED_W-1:0] rate_q;
   logic               halted_q;
   vec4_type           start_pose;
   vec4_type           held_pose;
   logic [VAL_W-1:0]   timer_q;
   logic [VAL_W-1:0]   longest_q;
   int                 n_keys;
   logic [VAL_W-1:0]   key_time [MAX_KEYS_DEF];
   vec4_type           key_pose [MAX_KEYS_DEF];

   pose_type           pending_poses [$];
   int                 beat_no;

   // a + floor((b - a) * frac / 65536), wrapped to 32 bits
   function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] from_v,
                                              input logic [VAL_W-1:0] to_v,
                                              input logic [FRAC_W-1:0] frac);
      logic [VAL_W+1:0]   diff;
      logic signed [63:0] prod;
      diff = {{2{to_v[VAL_W-1]}}, to_v} - {{2{from_v[VAL_W-1]}}, from_v};
      prod = $signed({{30{diff[VAL_W+1]}}, diff}) * $signed({47'd0, frac});
      return from_v + prod[47:16];
   endfunction

   always @(posedge clock) begin : track
      logic [47:0]          rate_prod;
      logic [40:0]          sum;
      logic [VAL_W-1:0]     prev_t;
      vec4_type             prev_v;
      logic [VAL_W-1:0]     num;
      logic [VAL_W-1:0]     span;
      logic [47:0]          frac_wide;
      logic [FRAC_W-1:0]    frac;
      logic [REG_IDX_W-1:0] idx;
      pose_type             got;
      pose_type             want;
      int                   hit;
      int                   k;

      if (reset) begin
         rate_q     = SPEED_RESET;
         halted_q   = 1'b0;
         start_pose = '0;
         held_pose  = '0;
         timer_q    = '0;
         longest_q  = '0;
         n_keys     = 0;
         beat_no    = 0;
         pose_errors = 0;
         pending_poses.delete();
      end else begin
         // register writes land on the access cycle
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            idx = csr_paddr[CSR_ADDR_W-1:2];
            case (idx)
               REG_SPEED:   rate_q   = csr_pwdata[SPEED_W-1:0];
               REG_STOPPED: halted_q = csr_pwdata[0];
               REG_INIT_X, REG_INIT_Y, REG_INIT_Z, REG_INIT_W: begin
                  start_pose[idx - REG_INIT_X] = csr_pwdata;
                  held_pose[idx - REG_INIT_X]  = csr_pwdata;
               end
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.comp   = rsp_tdata;
            got.at_end = rsp_tuser;
            beat_no++;
            if (pending_poses.size() == 0) begin
               pose_errors++;
               if (pose_errors <= 10)
                  $display("result beat %0d arrived with nothing expected: %h end=%b",
                           beat_no, got.comp, got.at_end);
            end else begin
               want = pending_poses.pop_front();
               if (got !== want) begin
                  pose_errors++;
                  if (pose_errors <= 10) begin
                     $display("result beat %0d mismatch: expected x=%h y=%h z=%h w=%h end=%b",
                              beat_no, want.comp[0], want.comp[1], want.comp[2],
                              want.comp[3], want.at_end);
                     $display("   got x=%h y=%h z=%h w=%h end=%b",
                              got.comp[0], got.comp[1], got.comp[2], got.comp[3],
                              got.at_end);
                  end
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_APPEND) begin
               // a full table drops the key and leaves the duration alone
               if (n_keys < MAX_KEYS_DEF) begin
                  if (req_tdata[63:32] > longest_q)
                     longest_q = req_tdata[63:32];
                  key_time[n_keys] = req_tdata[63:32];
                  key_pose[n_keys] = req_tdata[191:64];
                  n_keys++;
               end
            end else if (!halted_q) begin
               rate_prod = {16'd0, req_tdata[31:0]} * {32'd0, rate_q};
               sum       = {9'd0, timer_q} + {1'b0, rate_prod[47:8]};
               timer_q   = (sum[40:32] != 0) ? '1 : sum[31:0];

               // keys are searched in order of addition
               hit = -1;
               for (k = 0; k < n_keys; k++)
                  if (hit < 0 && key_time[k] >= timer_q)
                     hit = k;

               if (hit >= 0) begin
                  prev_t = (hit != 0) ? key_time[hit-1] : '0;
                  prev_v = (hit != 0) ? key_pose[hit-1] : start_pose;
                  num    = timer_q - prev_t;
                  span   = key_time[hit] - prev_t;
                  if (span == 0) begin
                     frac = FRAC_ONE;
                  end else begin
                     frac_wide = {num, 16'd0} / {16'd0, span};
                     frac = (frac_wide > {31'd0, FRAC_ONE}) ? FRAC_ONE : frac_wide[FRAC_W-1:0];
                  end
                  for (k = 0; k < COMP_N; k++)
                     held_pose[k] = blend(prev_v[k], key_pose[hit][k], frac);
               end

               want.at_end = (n_keys != 0) && (timer_q >= longest_q);
               if (want.at_end)
                  held_pose = key_pose[n_keys-1];
               want.comp = held_pose;
               pending_poses.insert(pending_poses.size(), want);
            end
         end
      end
      poses_due = pending_poses.size();
   end

endmodule

// ----- tb/sv/tb_vec4_keyframe_lerp.sv -----
// Stimulus, idling and verdict for the vec4 keyframe interpolator.
module tb_vec4_keyframe_lerp;
   import vkl_pkg::*;

   // Cycles to let a tick in flight finish before touching registers.
   localparam int SETTLE_CYCLES = 80;
   // Cycles with no beat and no register write before giving up.
   localparam int IDLE_LIMIT    = 2000;
   // Mean timer advance per tick in Q16.16, sized so the random ticks walk
   // most of the 32-bit time range across the key table.
   localparam longint STEP_TARGET = 10_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = FUNC_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int  pose_errors;
   int  poses_due;
   int  idle_cycles = 0;
   // set during the stretch where neither side may idle
   bit  no_gaps = 1'b0;

   always #5 clock = ~clock;

   vec4_keyframe_lerp i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   keyframe_pose_check i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .pose_errors (pose_errors),
      .poses_due   (poses_due)
   );

   // Stall the result side about 12 percent of the time, never in the
   // no-gap stretch.
   always @(negedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 12);
   end

   // Watchdog: any beat or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [127:0] any_pose();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // Largest delta that keeps the mean step near STEP_TARGET at this rate.
   function automatic logic [31:0] delta_bound(input logic [SPEED_W-1:0] rate);
      longint b;
      if (rate == 0)
         return '1;
      b = (2 * STEP_TARGET * 256) / rate;
      return (b > 64'hFFFF_FFFF) ? '1 : b[31:0];
   endfunction

   // Setup cycle, then access cycle; the register takes the value at the
   // edge that closes the access cycle.
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Present one beat, idling first at random; return at the falling edge
   // after it was taken, with valid still high for the caller to reuse.
   task automatic send_beat(input logic func, input logic [31:0] delta,
                            input logic [31:0] key_t, input logic [127:0] key_v);
      while (!no_gaps && $urandom_range(0, 99) < 12) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = {key_v, key_t, delta};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, drain every expected result, then give the block time to
   // finish anything that emits nothing.
   task automatic settle();
      req_tvalid = 1'b0;
      while (poses_due != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly ticks with bounded or full-range deltas; the odd append is
   // dropped once the table is full but still toggles the key fields.
   task automatic play_random(input int count, input logic [31:0] dmax, input bit wide);
      logic [31:0] delta;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_beat(FUNC_APPEND, $urandom, $urandom, any_pose());
         end else begin
            delta = wide ? $urandom : $urandom_range(0, dmax);
            send_beat(FUNC_TICK, delta, $urandom, any_pose());
         end
      end
   endtask

   initial begin : stimulus
      logic [31:0]        key_t;
      logic [SPEED_W-1:0] rate;
      int                 k;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      settle();

      // --- directed part ---
      // No keys yet: emit the reset-time held value.
      send_beat(FUNC_TICK, 32'd0, 32'd0, '0);
      settle();
      // Extreme start values also load the held value.
      write_reg(REG_INIT_X, 32'h8000_0000);
      write_reg(REG_INIT_Y, 32'h7FFF_FFFF);
      write_reg(REG_INIT_Z, 32'hFFFF_FFFF);
      write_reg(REG_INIT_W, 32'h0000_0001);
      send_beat(FUNC_TICK, 32'd0, 32'd0, '0);
      settle();

      // Stopped: the largest tick must neither advance the timer nor emit,
      // while an append still lands the first key at time zero.
      write_reg(REG_STOPPED, 32'd1);
      send_beat(FUNC_TICK, 32'hFFFF_FFFF, 32'd0, '0);
      send_beat(FUNC_APPEND, 32'd0, 32'd0,
                {32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
      settle();
      write_reg(REG_STOPPED, 32'd0);
      write_reg(REG_SPEED, 32'd256);

      // Second key with opposite extremes in x and y, so the first segment swings
      // across the whole signed range.
      key_t = 32'h1000_0000 | ($urandom & 32'h0FFF_FFFF);
      send_beat(FUNC_APPEND, 32'd0, key_t,
                {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
      // Timer still zero on a key at time zero: zero span, fraction one.
      send_beat(FUNC_TICK, 32'd0, 32'd0, '0);

      // Fill the table in rising time order, except one key placed out of
      // order; the last key sits just below the top of the range.
      for (k = 2; k < MAX_KEYS_DEF; k++) begin
         if (k == MAX_KEYS_DEF - 1)
            key_t = 32'hFFFF_FF00;
         else if (k == 8)
            key_t = $urandom_range(1, 32'h0FFF_FFFF);
         else
            key_t = (k << 28) | ($urandom & 32'h0FFF_FFFF);
         send_beat(FUNC_APPEND, $urandom, key_t, any_pose());
      end
      // Table full: this key is dropped, duration and last key unchanged.
      send_beat(FUNC_APPEND, 32'd0, 32'hFFFF_FFFF, any_pose());
      send_beat(FUNC_TICK, 32'h0001_0000, 32'd0, '0);
      settle();

      // --- random part, phase by phase ---
      write_reg(REG_INIT_X, $urandom);
      write_reg(REG_INIT_Y, $urandom);
      write_reg(REG_INIT_Z, $urandom);
      write_reg(REG_INIT_W, $urandom);
      play_random(120, delta_bound(16'd256), 1'b0);
      settle();

      // Slowest nonzero rate: full-range deltas still make small steps.
      write_reg(REG_SPEED, 32'd1);
      play_random(80, delta_bound(16'd1), 1'b0);
      settle();

      // Stopped stretch with a random rate.
      rate = SPEED_W'($urandom_range(2, 16'hFFFE));
      write_reg(REG_SPEED, {16'd0, rate});
      write_reg(REG_STOPPED, 32'd1);
      play_random(25, 32'hFFFF_FFFF, 1'b1);
      settle();

      // Back-to-back stretch: no idling on either side.
      write_reg(REG_STOPPED, 32'd0);
      no_gaps = 1'b1;
      play_random(170, delta_bound(rate), 1'b0);
      settle();
      no_gaps = 1'b0;

      // Zero rate: the timer holds whatever the delta.
      write_reg(REG_SPEED, 32'd0);
      play_random(25, 32'hFFFF_FFFF, 1'b1);
      settle();

      // Top rate and largest delta: saturate the timer and sit at the end.
      write_reg(REG_SPEED, 32'h0000_FFFF);
      write_reg(REG_INIT_X, 32'h7FFF_FFFF);
      write_reg(REG_INIT_Y, 32'h8000_0000);
      write_reg(REG_INIT_Z, 32'h0000_0000);
      write_reg(REG_INIT_W, 32'hFFFF_FFFF);
      send_beat(FUNC_TICK, 32'hFFFF_FFFF, 32'd0, '0);
      play_random(100, 32'hFFFF_FFFF, 1'b1);
      settle();

      if (pose_errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
